>>> rtl/hte_pkg.sv
// shared constants, function codes and lane control type for the transform engine
`timescale 1ns / 1ps
package hte_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FUNC_W          = 3;
  localparam int IDX_W           = 5;
  localparam int STORE_DEPTH     = 32;

  // function codes
  localparam logic [FUNC_W-1:0] FN_LOAD      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POINT     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_VECTOR    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_NORMAL    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INV_POINT = 3'd4;
  localparam logic [FUNC_W-1:0] FN_INV_NORM  = 3'd5;

  // per-cycle control of the dot-product lanes
  typedef struct packed {
    logic       first;
    logic       mul;
    logic       add;
    logic       fin;
    logic [1:0] idx;
  } lane_ctl_t;

endpackage

>>> rtl/hte_in_if.sv
// input and result channel interfaces
`timescale 1ns / 1ps
interface hte_in_if import hte_pkg::*; #(parameter int CW = COORD_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [IDX_W-1:0]     entry_index;
  logic signed [CW-1:0] load_value;
  logic signed [CW-1:0] coord_x;
  logic signed [CW-1:0] coord_y;
  logic signed [CW-1:0] coord_z;
  modport source (output valid, func, entry_index, load_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, func, entry_index, load_value, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface hte_out_if import hte_pkg::*; #(parameter int CW = COORD_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 range_error;
  modport source (output valid, out_x, out_y, out_z, range_error, input ready);
  modport sink (input valid, out_x, out_y, out_z, range_error, output ready);
endinterface

>>> rtl/hte_lane.sv
// one row lane: multiply-accumulate of a matrix row with the input, then shift and saturate
`timescale 1ns / 1ps
module hte_lane import hte_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  lane_ctl_t            ctl,
  input  logic                 trans,
  input  logic signed [CW-1:0] m_elem [4],
  input  logic signed [CW-1:0] p_elem [3],
  output logic signed [CW-1:0] v_r,
  output logic                 sat_r
);
  localparam int AW = 2 * CW + 2;

  logic signed [2*CW-1:0] prod_r;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic signed [AW-1:0]   sh;
  logic                   ovf;

  // one product a cycle
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= m_elem[ctl.idx] * p_elem[ctl.idx];
    end
  end

  // accumulator, seeded with the aligned translation column for points
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.first) begin
      acc_nxt = trans ? (AW'(m_elem[3]) <<< FB) : '0;
    end else if (ctl.add) begin
      acc_nxt = acc_r + AW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // reduce to Q format and saturate
  assign sh  = acc_r >>> FB;
  assign ovf = !((&sh[AW-1:CW-1]) || !(|sh[AW-1:CW-1]));

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      sat_r <= ovf;
      if (!ovf) begin
        v_r <= sh[CW-1:0];
      end else if (sh[AW-1]) begin
        v_r <= {1'b1, {(CW-1){1'b0}}};
      end else begin
        v_r <= {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

endmodule

>>> rtl/hte_div.sv
// fixed-point divider, four quotient bits a cycle, saturating result
`timescale 1ns / 1ps
module hte_div import hte_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] num,
  input  logic signed [CW-1:0] den,
  output logic                 done_r,
  output logic signed [CW-1:0] quot,
  output logic                 ovf
);
  localparam int NB    = CW + FB;
  localparam int NBP   = ((NB + 3) / 4) * 4;
  localparam int STEPS = NBP / 4;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [NBP-1:0]   n_r, q_r, n_t, q_t;
  logic [CW-1:0]    d_r, abs_n, abs_d;
  logic [CW:0]      rem_r, rem_t;
  logic             neg_r, busy_r;
  logic [CNT_W-1:0] cnt_r;

  assign abs_n = num[CW-1] ? CW'(-num) : CW'(num);
  assign abs_d = den[CW-1] ? CW'(-den) : CW'(den);

  // four restoring steps
  always_comb begin
    rem_t = rem_r;
    n_t   = n_r;
    q_t   = q_r;
    for (int i = 0; i < 4; i++) begin
      rem_t = {rem_t[CW-1:0], n_t[NBP-1]};
      n_t   = n_t << 1;
      if (rem_t >= {1'b0, d_r}) begin
        rem_t = rem_t - {1'b0, d_r};
        q_t   = {q_t[NBP-2:0], 1'b1};
      end else begin
        q_t   = {q_t[NBP-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {{(NBP-CW){1'b0}}, abs_n} << FB;
      d_r   <= abs_d;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= num[CW-1] ^ den[CW-1];
    end else if (busy_r) begin
      n_r   <= n_t;
      rem_r <= rem_t;
      q_r   <= q_t;
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    if (neg_r) begin
      ovf = (|q_r[NBP-1:CW]) || (q_r[CW-1] && (|q_r[CW-2:0]));
    end else begin
      ovf = |q_r[NBP-1:CW-1];
    end
    if (ovf) begin
      quot = neg_r ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      quot = neg_r ? CW'(-q_r[CW-1:0]) : q_r[CW-1:0];
    end
  end

endmodule

>>> rtl/homogeneous_transform_engine_unit.sv
// top level: matrix store, row lanes, dividers and result merge
//
// Homogeneous 4x4 transform engine, Q-format signed fixed point.
// Input channel in_if carries one word per handshake: func selects a matrix
// load (entry_index, load_value) or a point, vector, normal, inverse point or
// inverse normal transform of coord_x/y/z. Loads and unused codes give no
// result; each transform gives one word on out_if.
// Four row lanes form the dot products, one product per lane per cycle; a point
// whose w is neither zero nor one also runs three dividers in parallel, each
// retiring four quotient bits a cycle (Q16.16 by default). One item is in
// work at a time; the next is accepted when the engine is back to idle.
// The result sits in an output register: while the receiver stalls, the
// engine still accepts and works the next item and holds it until the
// register frees.
// Reset (synchronous, active low) puts the identity matrix in both the
// forward and inverse halves and empties the output register.
`timescale 1ns / 1ps
module homogeneous_transform_engine_unit import hte_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hte_in_if.sink    in_if,
  hte_out_if.source out_if
);
  localparam int CW = COORD_WIDTH;
  localparam logic signed [CW-1:0] FIX_ONE = CW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] CW_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CW_MIN  = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_RED, S_MERGE, S_DIV, S_DONE} state_t;

  state_t               state_r;
  logic [1:0]           cnt_r;
  logic [FUNC_W-1:0]    func_r;
  logic signed [CW-1:0] p_r [3];
  logic signed [CW-1:0] mat_r [STORE_DEPTH];
  logic signed [CW-1:0] m_sel [4][4];
  logic signed [CW-1:0] v_r [4];
  logic [3:0]           sat_r;
  logic signed [CW-1:0] res_r [3];
  logic                 err_r;
  logic                 out_valid_r, out_err_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [2:0]           div_done;
  logic signed [CW-1:0] div_q [3];
  logic [2:0]           div_ovf;
  lane_ctl_t            ctl;
  logic                 accept, is_pt, is_inv, is_tr, lane_err, do_div, w_zero, div_start;

  assign accept = in_if.valid && in_if.ready;
  assign is_pt  = (func_r == FN_POINT) || (func_r == FN_INV_POINT);
  assign is_inv = (func_r == FN_NORMAL) || (func_r == FN_INV_POINT);
  assign is_tr  = (func_r == FN_NORMAL) || (func_r == FN_INV_NORM);

  // matrix store, identity in both halves after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        mat_r[i] <= (((i % 16) % 5) == 0) ? FIX_ONE : '0;
      end
    end else if (accept && in_if.func == FN_LOAD) begin
      mat_r[in_if.entry_index] <= in_if.load_value;
    end
  end

  // element selection per lane: half and transpose
  for (genvar r = 0; r < 4; r++) begin : g_sel
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m_sel[r][c] = is_tr ?
                           (is_inv ? mat_r[16 + c*4 + r] : mat_r[c*4 + r]) :
                           (is_inv ? mat_r[16 + r*4 + c] : mat_r[r*4 + c]);
    end
  end

  // lane sequencing
  always_comb begin
    ctl.first = (state_r == S_MAC) && (cnt_r == 2'd0);
    ctl.mul   = (state_r == S_MAC) && (cnt_r != 2'd3);
    ctl.add   = (state_r == S_MAC) && (cnt_r != 2'd0);
    ctl.fin   = (state_r == S_RED);
    ctl.idx   = cnt_r;
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    hte_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .trans  (is_pt),
      .m_elem (m_sel[r]),
      .p_elem (p_r),
      .v_r    (v_r[r]),
      .sat_r  (sat_r[r])
    );
  end

  // perspective dividers, one per component
  for (genvar r = 0; r < 3; r++) begin : g_div
    hte_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (div_start),
      .num    (v_r[r]),
      .den    (v_r[3]),
      .done_r (div_done[r]),
      .quot   (div_q[r]),
      .ovf    (div_ovf[r])
    );
  end

  // merge decisions
  assign lane_err  = (|sat_r[2:0]) || (is_pt && sat_r[3]);
  assign w_zero    = is_pt && (v_r[3] == '0);
  assign do_div    = is_pt && (v_r[3] != FIX_ONE) && !w_zero;
  assign div_start = (state_r == S_MERGE) && do_div;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_if.func != FN_LOAD && in_if.func <= FN_INV_NORM) begin
            func_r  <= in_if.func;
            p_r[0]  <= in_if.coord_x;
            p_r[1]  <= in_if.coord_y;
            p_r[2]  <= in_if.coord_z;
            cnt_r   <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd3) begin
            state_r <= S_RED;
          end
        end
        S_RED: begin
          state_r <= S_MERGE;
        end
        S_MERGE: begin
          err_r <= lane_err || w_zero;
          for (int r = 0; r < 3; r++) begin
            if (w_zero && v_r[r] != '0) begin
              res_r[r] <= v_r[r][CW-1] ? CW_MIN : CW_MAX;
            end else begin
              res_r[r] <= v_r[r];
            end
          end
          state_r <= do_div ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (&div_done) begin
            res_r   <= div_q;
            err_r   <= err_r || (|div_ovf);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // old word leaves and the new one loads in the same cycle
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_r[0];
            out_y_r     <= res_r[1];
            out_z_r     <= res_r[2];
            out_err_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.out_x       = out_x_r;
  assign out_if.out_y       = out_y_r;
  assign out_if.out_z       = out_z_r;
  assign out_if.range_error = out_err_r;

endmodule

>>> rtl/hte_chk.sv
// port-level checks on the transform engine, bound to the top level
`timescale 1ns / 1ps
module hte_chk import hte_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CW-1:0]     out_x
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled word keeps its x component
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x))
    else $error("result payload changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // a transform occupies the engine the next cycle
  a_busy_after_xform: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func != FN_LOAD && in_func <= FN_INV_NORM |=> !in_ready)
    else $error("engine took a word while working on a transform");

endmodule

bind homogeneous_transform_engine_unit hte_chk #(.CW(COORD_WIDTH)) u_hte_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_func   (in_if.func),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_x     (out_if.out_x)
);
